### rtl/ahblr_pkg.sv
// Package for the ASCII-hex block link receiver.
// Holds event, action and status codes, limits and the hex digit decoder.
// No dependencies.
package ahblr_pkg;

  // Receive buffer size in characters; the frame stops taking characters at RX_CHARS - 1
  localparam int RX_CHARS = 256;
  localparam int CHAR_W   = 9;
  localparam logic [CHAR_W-1:0] CHAR_LAST = CHAR_W'(RX_CHARS - 1);

  localparam int LIMIT_W  = 4;
  localparam int CFG_IDX_W = 4;

  localparam logic [7:0] ACK_BYTE = 8'h60;
  localparam logic [7:0] NAK_BYTE = 8'hE0;
  localparam logic [7:0] EOT_CHAR = 8'h03;
  localparam logic [7:0] HEX_GAP  = 8'd7;
  localparam logic [7:0] ZERO_CHAR = 8'h30;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NAK_LIMIT   = CFG_IDX_W'(1);
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = LIMIT_W'(5);

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_CHAR  = 2'd1,
    REQ_TIMER = 2'd2,
    REQ_TERM  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_RESEND = 2'd1,
    ACT_NAK    = 2'd2,
    ACT_DONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_NAKS    = 2'd2,
    ST_USER    = 2'd3
  } status_t;

  typedef enum logic {
    PH_IDLE  = 1'b0,
    PH_ARMED = 1'b1
  } phase_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] retry_limit;
    logic [LIMIT_W-1:0] nak_limit;
  } limits_t;

  typedef struct packed {
    action_t action;
    status_t status;
  } result_t;

  // ASCII hex digit to value, 8-bit wrap, no masking of bad digits
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] t;
    t = c - ZERO_CHAR;
    if (t > 8'd9) begin
      t = t - HEX_GAP;
    end
    return t;
  endfunction

endpackage

### rtl/ahblr_core.sv
// Protocol state and per-event decision logic of the link receiver.
// Depends on ahblr_pkg.
module ahblr_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  ahblr_pkg::req_t      req,
  input  logic [7:0]           rx_char,
  input  ahblr_pkg::limits_t   limits,
  output ahblr_pkg::result_t   result
);
  import ahblr_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [LIMIT_W-1:0]  retry_count_r, retry_count_nxt;
  logic [LIMIT_W-1:0]  nak_count_r, nak_count_nxt;
  logic [CHAR_W-1:0]   char_count_r, char_count_nxt;
  logic [7:0]          high_char_r, high_char_nxt;
  logic [7:0]          byte_count_r, byte_count_nxt;
  logic [7:0]          first_byte_r, first_byte_nxt;
  logic [7:0]          length_byte_r, length_byte_nxt;
  logic [7:0]          xor_r, xor_nxt;

  // Character taken into the frame
  logic [7:0]          hi_val, lo_val;
  logic [7:0]          pair_byte;
  logic                odd_char;
  logic [CHAR_W-1:0]   tc_char_count;
  logic [7:0]          tc_high_char, tc_byte_count, tc_first, tc_length, tc_xor;
  logic                char_taken, eot_seen, frame_ok, frame_ack;
  logic [LIMIT_W-1:0]  retry_inc, nak_inc;
  logic                retry_more, nak_more, armed;

  assign armed      = (phase_r == PH_ARMED);
  assign odd_char   = char_count_r[0];
  assign hi_val     = digit_value(high_char_r);
  assign lo_val     = digit_value(rx_char);
  assign pair_byte  = {hi_val[3:0], 4'h0} | lo_val;
  assign char_taken = armed && (char_count_r < CHAR_LAST);
  assign eot_seen   = (rx_char == EOT_CHAR);
  assign retry_inc  = retry_count_r + LIMIT_W'(1);
  assign nak_inc    = nak_count_r + LIMIT_W'(1);
  assign retry_more = (retry_inc < limits.retry_limit);
  assign nak_more   = (nak_inc < limits.nak_limit);

  // Frame registers after taking the character
  always_comb begin
    tc_char_count = char_count_r + CHAR_W'(1);
    tc_high_char  = high_char_r;
    tc_byte_count = byte_count_r;
    tc_first      = first_byte_r;
    tc_length     = length_byte_r;
    tc_xor        = xor_r;
    if (!odd_char) begin
      tc_high_char = rx_char;
    end else begin
      if (byte_count_r == 8'd0) begin
        tc_first = pair_byte;
      end
      if (byte_count_r == 8'd1) begin
        tc_length = pair_byte;
      end
      tc_xor        = xor_r ^ pair_byte;
      tc_byte_count = byte_count_r + 8'd1;
    end
  end

  // Frame check on the updated registers
  assign frame_ack = (tc_first == ACK_BYTE);
  assign frame_ok  = (frame_ack || (tc_first == NAK_BYTE)) && (tc_byte_count >= 8'd3) &&
                     (tc_length == (tc_byte_count - 8'd3)) && (tc_xor == 8'd0);

  // Next state
  always_comb begin
    phase_nxt       = phase_r;
    retry_count_nxt = retry_count_r;
    nak_count_nxt   = nak_count_r;
    char_count_nxt  = char_count_r;
    high_char_nxt   = high_char_r;
    byte_count_nxt  = byte_count_r;
    first_byte_nxt  = first_byte_r;
    length_byte_nxt = length_byte_r;
    xor_nxt         = xor_r;
    if (step_en) begin
      unique case (req)
        REQ_START: begin
          phase_nxt       = PH_ARMED;
          retry_count_nxt = '0;
          nak_count_nxt   = '0;
          char_count_nxt  = '0;
          high_char_nxt   = '0;
          byte_count_nxt  = '0;
          first_byte_nxt  = '0;
          length_byte_nxt = '0;
          xor_nxt         = '0;
        end
        REQ_TERM: begin
          phase_nxt = PH_IDLE;
        end
        REQ_TIMER: begin
          if (armed) begin
            retry_count_nxt = retry_inc;
            if (retry_more) begin
              char_count_nxt  = '0;
              high_char_nxt   = '0;
              byte_count_nxt  = '0;
              first_byte_nxt  = '0;
              length_byte_nxt = '0;
              xor_nxt         = '0;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        REQ_CHAR: begin
          if (char_taken) begin
            char_count_nxt  = tc_char_count;
            high_char_nxt   = tc_high_char;
            byte_count_nxt  = tc_byte_count;
            first_byte_nxt  = tc_first;
            length_byte_nxt = tc_length;
            xor_nxt         = tc_xor;
            if (eot_seen) begin
              if (!frame_ok) begin
                nak_count_nxt = nak_inc;
              end
              if ((frame_ok && frame_ack) || (!frame_ok && !nak_more)) begin
                phase_nxt = PH_IDLE;
              end else begin
                // resend request or NAK request: start a fresh frame
                char_count_nxt  = '0;
                high_char_nxt   = '0;
                byte_count_nxt  = '0;
                first_byte_nxt  = '0;
                length_byte_nxt = '0;
                xor_nxt         = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result of the current event
  always_comb begin
    result.action = ACT_NONE;
    result.status = ST_OK;
    unique case (req)
      REQ_START: ;
      REQ_TERM: begin
        result.action = ACT_DONE;
        result.status = ST_USER;
      end
      REQ_TIMER: begin
        if (armed) begin
          if (retry_more) begin
            result.action = ACT_RESEND;
          end else begin
            result.action = ACT_DONE;
            result.status = ST_TIMEOUT;
          end
        end
      end
      REQ_CHAR: begin
        if (char_taken && eot_seen) begin
          priority if (frame_ok && frame_ack) begin
            result.action = ACT_DONE;
          end else if (frame_ok) begin
            result.action = ACT_RESEND;
          end else if (nak_more) begin
            result.action = ACT_NAK;
          end else begin
            result.action = ACT_DONE;
            result.status = ST_NAKS;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      retry_count_r <= '0;
      nak_count_r   <= '0;
      char_count_r  <= '0;
      high_char_r   <= '0;
      byte_count_r  <= '0;
      first_byte_r  <= '0;
      length_byte_r <= '0;
      xor_r         <= '0;
    end else begin
      phase_r       <= phase_nxt;
      retry_count_r <= retry_count_nxt;
      nak_count_r   <= nak_count_nxt;
      char_count_r  <= char_count_nxt;
      high_char_r   <= high_char_nxt;
      byte_count_r  <= byte_count_nxt;
      first_byte_r  <= first_byte_nxt;
      length_byte_r <= length_byte_nxt;
      xor_r         <= xor_nxt;
    end
  end

endmodule

### rtl/ascii_hex_block_link_receiver_top.sv
// Top level of the ASCII-hex block link receiver: input register, limit
// registers, output register. Depends on ahblr_pkg and ahblr_core.
//
// Each event (start, received character, timer expiry, terminate) yields exactly one
// result (action, status). Events are taken one per clock while the output is not stalled;
// an accepted event is held in the input register, and its result is loaded into the
// output register once that register can take it, and from there shows on the out_ ports.
// The frame registers (digit pairing, byte count, running XOR and the end-of-text check)
// are updated between the input and output registers.
// in_stall rises only while the output register holds a result that is stalled and the
// input register is also full. Limit registers reset to 5 and are written with
// cfg_valid; cfg_ready is always high. No clearing pass after reset.
module ascii_hex_block_link_receiver_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_req_type,
  input  logic [7:0]                     in_rx_char,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_action,
  output logic [1:0]                     out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ahblr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ahblr_pkg::LIMIT_W-1:0]  cfg_wdata
);
  import ahblr_pkg::*;

  logic        in_full_r, in_full_nxt;
  req_t        req_r;
  logic [7:0]  char_r;
  logic        advance, in_accept, step_en;
  limits_t     limits_r;
  result_t     core_res;
  result_t     out_res_r;
  logic        out_valid_r, out_valid_nxt;

  // Input register moves on whenever the output register can take a result
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_full_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign step_en   = in_full_r && advance;

  always_comb begin
    in_full_nxt = in_full_r;
    if (in_accept) begin
      in_full_nxt = 1'b1;
    end else if (advance) begin
      in_full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else begin
      in_full_r <= in_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r  <= req_t'(in_req_type);
      char_r <= in_rx_char;
    end
  end

  // Limit registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.retry_limit <= LIMIT_RESET;
      limits_r.nak_limit   <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_RETRY_LIMIT) begin
        limits_r.retry_limit <= cfg_wdata;
      end
      if (cfg_index == CFG_NAK_LIMIT) begin
        limits_r.nak_limit <= cfg_wdata;
      end
    end
  end

  ahblr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .req     (req_r),
    .rx_char (char_r),
    .limits  (limits_r),
    .result  (core_res)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_res_r.action;
  assign out_status = out_res_r.status;

endmodule

### rtl/ahblr_checker.sv
// Port-level checks for the link receiver, bound to the top level.
// Depends on ahblr_pkg and ascii_hex_block_link_receiver_top.
module ahblr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [1:0]                      in_req_type,
  input logic [7:0]                      in_rx_char,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [1:0]                      out_action,
  input logic [1:0]                      out_status
);
  import ahblr_pkg::*;

  // A stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_req_type) && $stable(in_rx_char))
    else $error("stalled input transaction changed");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action) && $stable(out_status))
    else $error("stalled result changed");

  // Status only carries meaning on a finish
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action != ACT_DONE) |-> out_status == ST_OK)
    else $error("status set without finish");

  // Input side backs up only behind a stalled, full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // A terminate accepted on an empty pipe finishes with user status
  a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == REQ_TERM) && !out_valid && !in_stall
      ##1 !out_stall |=> out_valid && (out_action == ACT_DONE) && (out_status == ST_USER))
    else $error("terminate did not finish with user status");

endmodule

bind ascii_hex_block_link_receiver_top ahblr_checker u_ahblr_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench for ascii_hex_block_link_receiver_top.
// Feeds link events through a queued driver, predicts every reply in-line and
// checks it in a monitor. Depends on ahblr_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
  import ahblr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_LEN    = 300;
  localparam int IDLE_PCT    = 25;

  typedef struct packed {
    req_t       req;
    logic [7:0] ch;
  } link_evt_t;

  // Ways a generated frame can be spoiled
  typedef enum int {
    FL_NONE,
    FL_SUM,
    FL_LEN,
    FL_HEAD,
    FL_SHORT,
    FL_ODD
  } flaw_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_req_type = REQ_START;
  logic [7:0]           in_rx_char = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_action;
  logic [1:0]           out_status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RETRY_LIMIT;
  logic [LIMIT_W-1:0]   cfg_wdata = LIMIT_RESET;

  ascii_hex_block_link_receiver_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_rx_char  (in_rx_char),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_action  (out_action),
    .out_status  (out_status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always #5 clk = ~clk;

  link_evt_t pending_events[$];
  result_t   expected_replies[$];

  // Shadow of the link receiver state
  phase_t             armed = PH_IDLE;
  logic [3:0]         timer_tries = '0;
  logic [3:0]         bad_frames = '0;
  logic [CHAR_W-1:0]  rx_count = '0;
  logic [7:0]         hi_digit = '0;
  logic [7:0]         pair_count = '0;
  logic [7:0]         head_byte = '0;
  logic [7:0]         len_byte = '0;
  logic [7:0]         xor_acc = '0;
  logic [LIMIT_W-1:0] lim_retry = LIMIT_RESET;
  logic [LIMIT_W-1:0] lim_nak = LIMIT_RESET;

  // Traffic shaping, set from the stimulus process at the falling edge
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;
  int   hold_asks = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  int evt_added = 0;
  int events_taken = 0;
  int replies_checked = 0;
  int mismatches = 0;
  int resend_asks = 0;
  int nak_asks = 0;
  int finish_tally[4] = '{0, 0, 0, 0};
  int reg_writes = 0;
  int cycle_count = 0;

  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = c - 8'h30;
    if (v > 8'd9) v = v - 8'd7;
    return v;
  endfunction

  function automatic void drop_frame();
    rx_count   = '0;
    hi_digit   = '0;
    pair_count = '0;
    head_byte  = '0;
    len_byte   = '0;
    xor_acc    = '0;
  endfunction

  function automatic bit frame_ok();
    if (head_byte != ACK_BYTE && head_byte != NAK_BYTE) return 1'b0;
    if (pair_count < 8'd3) return 1'b0;
    if (len_byte != pair_count - 8'd3) return 1'b0;
    return xor_acc == 8'h00;
  endfunction

  // Next reply of the link receiver for one event; updates the shadow state
  function automatic result_t predict_reply(input req_t req, input logic [7:0] ch);
    result_t    res;
    logic [7:0] pair;
    res.action = ACT_NONE;
    res.status = ST_OK;
    case (req)
      REQ_START: begin
        armed       = PH_ARMED;
        timer_tries = '0;
        bad_frames  = '0;
        drop_frame();
      end
      REQ_TERM: begin
        armed      = PH_IDLE;
        res.action = ACT_DONE;
        res.status = ST_USER;
      end
      REQ_TIMER: begin
        if (armed == PH_ARMED) begin
          timer_tries = timer_tries + 1'b1;
          if (timer_tries < lim_retry) begin
            res.action = ACT_RESEND;
            drop_frame();
          end else begin
            armed      = PH_IDLE;
            res.action = ACT_DONE;
            res.status = ST_TIMEOUT;
          end
        end
      end
      default: begin
        // characters past the buffer end are dropped, EOT included
        if (armed == PH_ARMED && rx_count < CHAR_LAST) begin
          if (!rx_count[0]) begin
            hi_digit = ch;
          end else begin
            pair = (nibble_of(hi_digit) << 4) | nibble_of(ch);
            if (pair_count == 8'd0) head_byte = pair;
            else if (pair_count == 8'd1) len_byte = pair;
            xor_acc    = xor_acc ^ pair;
            pair_count = pair_count + 1'b1;
          end
          rx_count = rx_count + 1'b1;
          if (ch == EOT_CHAR) begin
            if (frame_ok()) begin
              if (head_byte == ACK_BYTE) begin
                armed      = PH_IDLE;
                res.action = ACT_DONE;
              end else begin
                res.action = ACT_RESEND;
                drop_frame();
              end
            end else begin
              bad_frames = bad_frames + 1'b1;
              if (bad_frames < lim_nak) begin
                res.action = ACT_NAK;
                drop_frame();
              end else begin
                armed      = PH_IDLE;
                res.action = ACT_DONE;
                res.status = ST_NAKS;
              end
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  // Driver: predicts on each accepted transaction, then offers the next event
  always @(posedge clk) begin
    link_evt_t nxt;
    result_t   reply;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        reply = predict_reply(req_t'(in_req_type), in_rx_char);
        expected_replies.push_back(reply);
        events_taken = events_taken + 1;
        if (reply.action == ACT_DONE) finish_tally[reply.status] += 1;
        else if (reply.action == ACT_RESEND) resend_asks += 1;
        else if (reply.action == ACT_NAK) nak_asks += 1;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_events.size() != 0 &&
            (tx_calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_events.pop_front();
          in_valid    <= 1'b1;
          in_req_type <= nxt.req;
          in_rx_char  <= nxt.ch;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each reply transaction and drives the stall
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected reply: action %0d status %0d", out_action, out_status);
          mismatches = mismatches + 1;
        end else begin
          want = expected_replies.pop_front();
          if (out_action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, out_action);
            mismatches = mismatches + 1;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches = mismatches + 1;
          end
          replies_checked = replies_checked + 1;
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !rx_calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ascii_hex_block_link_receiver_top regression: fail");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
  endfunction

  task automatic add_evt(input req_t req, input logic [7:0] ch);
    link_evt_t e;
    e.req = req;
    e.ch  = ch;
    pending_events.push_back(e);
    evt_added = evt_added + 1;
  endtask

  task automatic add_char(input logic [7:0] ch);
    add_evt(REQ_CHAR, ch);
  endtask

  // Encodes one frame (head, length, payload, check byte) in ASCII hex, then EOT
  task automatic add_frame(input logic [7:0] head, input int plen, input flaw_t flaw);
    logic [7:0] fb[$];
    logic [7:0] sum;
    logic [7:0] was;
    int         i;
    int         keep;
    sum = 8'h00;
    fb.push_back(head);
    fb.push_back(8'(plen));
    for (i = 0; i < plen; i++) fb.push_back(8'($urandom));
    for (i = 0; i < fb.size(); i++) sum = sum ^ fb[i];
    fb.push_back(sum);
    case (flaw)
      FL_SUM: fb[fb.size()-1] = fb[fb.size()-1] ^ 8'($urandom_range(1, 255));
      FL_LEN: begin
        // wrong length, checksum still balanced
        was   = fb[1];
        fb[1] = fb[1] + 8'($urandom_range(1, 255));
        fb[fb.size()-1] = fb[fb.size()-1] ^ was ^ fb[1];
      end
      FL_HEAD: begin
        was   = fb[0];
        fb[0] = 8'($urandom);
        if (fb[0] == ACK_BYTE || fb[0] == NAK_BYTE) fb[0] = fb[0] ^ 8'h01;
        fb[fb.size()-1] = fb[fb.size()-1] ^ was ^ fb[0];
      end
      FL_SHORT: begin
        keep = $urandom_range(0, 2);
        while (fb.size() > keep) void'(fb.pop_back());
      end
      default: ;
    endcase
    for (i = 0; i < fb.size(); i++) begin
      add_char(hex_char(fb[i][7:4]));
      add_char(hex_char(fb[i][3:0]));
    end
    if (flaw == FL_ODD) add_char(hex_char(4'($urandom)));
    add_char(EOT_CHAR);
  endtask

  // Runs past the receive buffer, then a timer tick clears the frame or ends the exchange
  task automatic add_overflow();
    int i;
    for (i = 0; i < int'(RX_CHARS) + 4; i++) add_char(hex_char(4'($urandom)));
    add_char(EOT_CHAR);
    add_evt(REQ_TIMER, 8'($urandom));
  endtask

  function automatic int rand_plen();
    return ($urandom_range(99) < 3) ? $urandom_range(100, 120) : $urandom_range(0, 6);
  endfunction

  function automatic logic [7:0] rand_head();
    return $urandom_range(1) ? ACK_BYTE : NAK_BYTE;
  endfunction

  function automatic flaw_t rand_flaw();
    return flaw_t'($urandom_range(FL_SUM, FL_ODD));
  endfunction

  // One armed exchange: mostly well-formed frames, some noise and misuse
  task automatic add_session();
    int steps;
    int s;
    int r;
    int i;
    add_evt(REQ_START, 8'($urandom));
    if ($urandom_range(9) == 0) begin
      // storm of expiries or bad frames, at times deep enough to reach a limit of 15
      steps = $urandom_range(12, 17);
      r = $urandom_range(1);
      for (s = 0; s < steps; s++) begin
        if (r != 0) add_evt(REQ_TIMER, 8'($urandom));
        else add_frame(rand_head(), $urandom_range(0, 3), rand_flaw());
      end
    end
    steps = $urandom_range(1, 8);
    for (s = 0; s < steps; s++) begin
      r = $urandom_range(99);
      if (r < 25) begin
        add_frame(ACK_BYTE, rand_plen(), FL_NONE);
      end else if (r < 45) begin
        add_frame(NAK_BYTE, rand_plen(), FL_NONE);
      end else if (r < 65) begin
        add_frame(rand_head(), rand_plen(), rand_flaw());
      end else if (r < 77) begin
        add_evt(REQ_TIMER, 8'($urandom));
      end else if (r < 81) begin
        add_evt(REQ_TERM, 8'($urandom));
      end else if (r < 84) begin
        add_evt(REQ_START, 8'($urandom));
      end else if (r < 95) begin
        for (i = $urandom_range(1, 12); i > 0; i--) add_char(8'($urandom));
        if ($urandom_range(1) != 0) add_char(EOT_CHAR);
      end else if (r < 97) begin
        add_overflow();
      end else begin
        add_evt(REQ_CHAR, 8'h00);
        add_evt(REQ_TIMER, 8'($urandom));
      end
    end
  endtask

  task automatic add_random(input int count);
    int mark;
    mark = evt_added;
    while (evt_added - mark < count) add_session();
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_replies.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_RETRY_LIMIT) lim_retry = val;
    else if (idx == CFG_NAK_LIMIT) lim_nak = val;
    reg_writes = reg_writes + 1;
  endtask

  task automatic set_limits(input logic [LIMIT_W-1:0] retry, input logic [LIMIT_W-1:0] nak);
    wait_drained();
    write_reg(CFG_RETRY_LIMIT, retry);
    write_reg(CFG_NAK_LIMIT, nak);
  endtask

  // Stimulus and end of run
  initial begin
    int leftover;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle events, restart, each frame fault, overflow, terminate
    add_evt(REQ_CHAR, 8'h00);
    add_evt(REQ_TIMER, 8'hFF);
    add_evt(REQ_TERM, 8'h00);
    add_evt(REQ_START, 8'hFF);
    add_evt(REQ_START, 8'h00);
    add_frame(NAK_BYTE, 0, FL_NONE);
    add_evt(REQ_TIMER, 8'h00);
    add_frame(ACK_BYTE, 1, FL_SUM);
    add_frame(ACK_BYTE, 0, FL_LEN);
    add_frame(ACK_BYTE, 2, FL_HEAD);
    add_frame(ACK_BYTE, 0, FL_SHORT);
    add_frame(NAK_BYTE, 1, FL_ODD);
    add_evt(REQ_START, 8'h00);
    add_overflow();
    add_frame(ACK_BYTE, 0, FL_NONE);
    add_evt(REQ_START, 8'h00);
    add_evt(REQ_TERM, 8'hFF);

    // tightest useful limits
    set_limits(4'd1, 4'd1);
    add_evt(REQ_START, 8'h00);
    add_evt(REQ_TIMER, 8'h00);
    add_evt(REQ_START, 8'h00);
    add_frame(ACK_BYTE, 1, FL_SUM);
    add_random(50);

    // widest limits, with a long hold on the reply side while events keep coming
    set_limits(4'd15, 4'd15);
    add_random(70);
    @(negedge clk);
    hold_asks = hold_asks + 1;

    // zero limits and writes to unused indexes
    set_limits(4'd0, 4'd0);
    write_reg(CFG_IDX_W'(2), 4'd1);
    write_reg(CFG_IDX_W'(15), 4'd9);
    add_evt(REQ_START, 8'h00);
    add_evt(REQ_TIMER, 8'h00);
    add_evt(REQ_START, 8'h00);
    add_frame(NAK_BYTE, 0, FL_SUM);
    add_random(40);

    // back-to-back stretch with no idling on either side
    set_limits(4'd3, 4'd9);
    @(negedge clk);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    add_random(100);
    wait_drained();
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    set_limits(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
    add_random(90);

    set_limits(LIMIT_RESET, LIMIT_RESET);
    add_random(70);

    wait_drained();
    repeat (10) @(negedge clk);
    leftover = expected_replies.size();
    if (leftover != 0) $error("%0d replies never arrived", leftover);

    $display("run: %0d events sent, %0d replies checked, %0d limit writes",
             events_taken, replies_checked, reg_writes);
    $display("outcomes: ok %0d, timeout %0d, nak limit %0d, user %0d, resend %0d, nak %0d",
             finish_tally[ST_OK], finish_tally[ST_TIMEOUT], finish_tally[ST_NAKS],
             finish_tally[ST_USER], resend_asks, nak_asks);
    if (mismatches == 0 && leftover == 0) begin
      $display("ascii_hex_block_link_receiver_top regression: pass");
    end else begin
      $display("ascii_hex_block_link_receiver_top regression: fail");
    end
    $finish;
  end

endmodule
